// ===== src/mrd_pkg.sv =====
// Shared types, constants and helpers for the Modbus RTU response deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package mrd_pkg;

  localparam int unsigned CNT_W     = 32;   // statistics counter width
  localparam int unsigned FCNT_W    = 9;    // frame byte count width
  localparam int unsigned Q_DEPTH   = 2;    // front/back queue depth
  localparam int unsigned Q_PTR_W   = 1;
  localparam int unsigned Q_CNT_W   = 2;

  localparam logic [FCNT_W-1:0] MIN_FRAME_BYTES = 9'd4;
  localparam logic [FCNT_W-1:0] LEN_EXCEPTION   = 9'd5;
  localparam logic [FCNT_W-1:0] LEN_WRITE       = 9'd8;
  localparam logic [FCNT_W-1:0] READ_OVERHEAD   = 9'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // input kinds as they arrive on func
  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_IOERR   = 2'd2;

  // Modbus function codes whose response length is decoded
  localparam logic [7:0] FC_READ_FIRST = 8'd1;
  localparam logic [7:0] FC_READ_LAST  = 8'd4;
  localparam logic [7:0] FC_WR_COIL    = 8'd5;
  localparam logic [7:0] FC_WR_REG     = 8'd6;
  localparam logic [7:0] FC_WR_COILS   = 8'd15;
  localparam logic [7:0] FC_WR_REGS    = 8'd16;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BYTE,
    OP_TIMEOUT,
    OP_IOERR,
    OP_CLOSED
  } op_e;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_OK      = 3'd1,
    ST_CRC     = 3'd2,
    ST_EXC     = 3'd3,
    ST_TIMEOUT = 3'd4,
    ST_IO      = 3'd5,
    ST_CLOSED  = 3'd6
  } status_e;

  // one classified item between front and back
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  // Modbus CRC-16, one byte, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/modbus_rtu_response_deframer.sv =====
// Top level of the Modbus RTU response deframer.
// Depends on mrd_pkg, mrd_front, mrd_fifo and mrd_back.
`default_nettype none

// Takes a Modbus RTU response one input transfer at a time (a received byte,
// a link timeout or a link I/O error) and returns exactly one result transfer
// for each. A running Modbus CRC-16 (reflected 0xA001, start 0xFFFF) covers
// the frame; the function code in byte 1 sets the expected length: 5 for an
// exception, 5 plus the byte count for reads 1 to 4, 8 for writes 5, 6, 15
// and 16, FRAME_CAPACITY otherwise, clamped to FRAME_CAPACITY. A frame never
// ends before 4 bytes and always ends at FRAME_CAPACITY bytes. A finished
// frame reports success, CRC error or exception; timeout and I/O error abort
// the frame. The six 32-bit statistics counters show their values after the
// input of the result they ride with, and all wrap. While port_open is 0 every
// input is answered with not-configured status and nothing changes; any
// write of port_open drops the partial frame. Write port_open only while the
// block is idle. Throughput is one transfer per clock while out_stall is
// low: the back end does the whole per-byte step (CRC byte update, length
// decode, counter update) combinationally. An input transfer is written
// into a queue entry, which moves into the result register once that
// register is empty or its result is taken. A two-entry queue lets the input
// side keep taking transfers while a result waits under stall.
module modbus_rtu_response_deframer #(
  parameter int unsigned FRAME_CAPACITY = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  rx_byte_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       byte_index_o,
  output logic             frame_done_o,
  output logic [2:0]       status_o,
  output logic [8:0]       frame_length_o,
  output logic [31:0]      bytes_received_count_o,
  output logic [31:0]      crc_error_count_o,
  output logic [31:0]      exception_count_o,
  output logic [31:0]      response_count_o,
  output logic [31:0]      timeout_count_o,
  output logic [31:0]      io_error_count_o
);
  import mrd_pkg::*;

  item_t in_item;
  item_t head_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  push;

  // input transfer completes whenever the queue has room
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  mrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .item_o      (in_item)
  );

  mrd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  mrd_back #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .q_empty_i              (q_empty),
    .q_head_i               (head_item),
    .q_pop_o                (q_pop),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .byte_index_o           (byte_index_o),
    .frame_done_o           (frame_done_o),
    .status_o               (status_o),
    .frame_length_o         (frame_length_o),
    .bytes_received_count_o (bytes_received_count_o),
    .crc_error_count_o      (crc_error_count_o),
    .exception_count_o      (exception_count_o),
    .response_count_o       (response_count_o),
    .timeout_count_o        (timeout_count_o),
    .io_error_count_o       (io_error_count_o)
  );

endmodule

`default_nettype wire

// ===== src/mrd_front.sv =====
// Front end: holds the port_open register and classifies each input item.
// Depends on mrd_pkg.
`default_nettype none

module mrd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic [1:0]    func_i,
  input  wire logic [7:0]    rx_byte_i,
  output mrd_pkg::item_t     item_o
);
  import mrd_pkg::*;

  logic port_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_open_q <= 1'b0;
    end else if (cfg_we_i) begin
      port_open_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    item_o.data = rx_byte_i;
    if (!port_open_q) begin
      item_o.op = OP_CLOSED;
    end else begin
      case (func_i)
        FUNC_BYTE:    item_o.op = OP_BYTE;
        FUNC_TIMEOUT: item_o.op = OP_TIMEOUT;
        FUNC_IOERR:   item_o.op = OP_IOERR;
        default:      item_o.op = OP_NOP;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/mrd_fifo.sv =====
// Short queue of classified items between the front and back ends.
// Depends on mrd_pkg.
`default_nettype none

module mrd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mrd_pkg::item_t push_item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output mrd_pkg::item_t      head_o
);
  import mrd_pkg::*;

  item_t                mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_q, wptr_d;
  logic [Q_PTR_W-1:0]   rptr_q, rptr_d;
  logic [Q_CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/mrd_back.sv =====
// Back end: frame tracking, CRC, length decode, statistics and result register.
// Depends on mrd_pkg.
`default_nettype none

module mrd_back #(
  parameter int unsigned FRAME_CAPACITY = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           q_empty_i,
  input  wire mrd_pkg::item_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         byte_index_o,
  output logic               frame_done_o,
  output logic [2:0]         status_o,
  output logic [8:0]         frame_length_o,
  output logic [31:0]        bytes_received_count_o,
  output logic [31:0]        crc_error_count_o,
  output logic [31:0]        exception_count_o,
  output logic [31:0]        response_count_o,
  output logic [31:0]        timeout_count_o,
  output logic [31:0]        io_error_count_o
);
  import mrd_pkg::*;

  localparam logic [FCNT_W-1:0] CAP = FCNT_W'(FRAME_CAPACITY);

  function automatic logic [FCNT_W-1:0] clamp_len(input logic [FCNT_W-1:0] n);
    return (n > CAP) ? CAP : n;
  endfunction

  // frame state
  logic [FCNT_W-1:0] rcnt_q, rcnt_d;
  logic [FCNT_W-1:0] exp_q, exp_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        fbyte_q, fbyte_d;
  // statistics
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  crcerr_q, crcerr_d;
  logic [CNT_W-1:0]  exc_q, exc_d;
  logic [CNT_W-1:0]  resp_q, resp_d;
  logic [CNT_W-1:0]  tmo_q, tmo_d;
  logic [CNT_W-1:0]  ioe_q, ioe_d;
  // result register
  logic              ovalid_q, ovalid_d;
  logic [7:0]        idx_q, idx_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [FCNT_W-1:0] flen_q, flen_d;

  logic [FCNT_W-1:0] rc_n, exp_n;
  logic [15:0]       crc_n;
  logic [7:0]        fb_n, b;
  logic              is_read_fb, is_read_b, is_write_b, ends;

  assign q_pop_o = !q_empty_i && (!ovalid_q || !out_stall_i);
  assign b       = q_head_i.data;

  // byte path, computed every cycle from the queue head
  always_comb begin
    rc_n       = rcnt_q + 1'b1;
    crc_n      = crc16_update(crc_q, b);
    fb_n       = (rcnt_q == 9'd1) ? b : fbyte_q;
    is_read_fb = !fbyte_q[7] && (fbyte_q >= FC_READ_FIRST) && (fbyte_q <= FC_READ_LAST);
    is_read_b  = (b >= FC_READ_FIRST) && (b <= FC_READ_LAST);
    is_write_b = (b == FC_WR_COIL) || (b == FC_WR_REG) ||
                 (b == FC_WR_COILS) || (b == FC_WR_REGS);
    exp_n      = exp_q;
    if (rcnt_q == 9'd1) begin
      if (b[7]) begin
        exp_n = clamp_len(LEN_EXCEPTION);
      end else if (is_read_b) begin
        exp_n = '0;
      end else if (is_write_b) begin
        exp_n = clamp_len(LEN_WRITE);
      end else begin
        exp_n = CAP;
      end
    end else if (rcnt_q == 9'd2 && is_read_fb) begin
      exp_n = clamp_len(READ_OVERHEAD + {1'b0, b});
    end
    ends = (rc_n >= MIN_FRAME_BYTES) &&
           (((exp_n != '0) && (rc_n >= exp_n)) || (rc_n >= CAP));
  end

  always_comb begin
    rcnt_d   = rcnt_q;
    exp_d    = exp_q;
    crc_d    = crc_q;
    fbyte_d  = fbyte_q;
    total_d  = total_q;
    crcerr_d = crcerr_q;
    exc_d    = exc_q;
    resp_d   = resp_q;
    tmo_d    = tmo_q;
    ioe_d    = ioe_q;
    ovalid_d = ovalid_q && out_stall_i;
    idx_d    = idx_q;
    done_d   = done_q;
    status_d = status_q;
    flen_d   = flen_q;

    if (q_pop_o) begin
      ovalid_d = 1'b1;
      idx_d    = '0;
      done_d   = 1'b0;
      status_d = ST_BUSY;
      flen_d   = '0;
      case (q_head_i.op)
        OP_CLOSED: begin
          status_d = ST_CLOSED;
        end
        OP_BYTE: begin
          idx_d = rcnt_q[7:0];
          if (ends) begin
            done_d  = 1'b1;
            flen_d  = rc_n;
            total_d = total_q + CNT_W'(rc_n);
            if (crc_n != '0) begin
              crcerr_d = crcerr_q + 1'b1;
              status_d = ST_CRC;
            end else if (fb_n[7]) begin
              exc_d    = exc_q + 1'b1;
              status_d = ST_EXC;
            end else begin
              resp_d   = resp_q + 1'b1;
              status_d = ST_OK;
            end
            rcnt_d  = '0;
            exp_d   = '0;
            crc_d   = CRC_INIT;
            fbyte_d = '0;
          end else begin
            rcnt_d  = rc_n;
            exp_d   = exp_n;
            crc_d   = crc_n;
            fbyte_d = fb_n;
          end
        end
        OP_TIMEOUT, OP_IOERR: begin
          done_d = 1'b1;
          flen_d = rcnt_q;
          if (q_head_i.op == OP_TIMEOUT) begin
            tmo_d    = tmo_q + 1'b1;
            status_d = ST_TIMEOUT;
          end else begin
            ioe_d    = ioe_q + 1'b1;
            status_d = ST_IO;
          end
          rcnt_d  = '0;
          exp_d   = '0;
          crc_d   = CRC_INIT;
          fbyte_d = '0;
        end
        default: begin
          status_d = ST_BUSY;
        end
      endcase
    end

    // a register write drops any partial frame
    if (cfg_we_i) begin
      rcnt_d  = '0;
      exp_d   = '0;
      crc_d   = CRC_INIT;
      fbyte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q   <= '0;
      exp_q    <= '0;
      crc_q    <= CRC_INIT;
      fbyte_q  <= '0;
      total_q  <= '0;
      crcerr_q <= '0;
      exc_q    <= '0;
      resp_q   <= '0;
      tmo_q    <= '0;
      ioe_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      rcnt_q   <= rcnt_d;
      exp_q    <= exp_d;
      crc_q    <= crc_d;
      fbyte_q  <= fbyte_d;
      total_q  <= total_d;
      crcerr_q <= crcerr_d;
      exc_q    <= exc_d;
      resp_q   <= resp_d;
      tmo_q    <= tmo_d;
      ioe_q    <= ioe_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    done_q   <= done_d;
    status_q <= status_d;
    flen_q   <= flen_d;
  end

  // counters change only when a result is loaded, so they always match it
  assign out_valid_o            = ovalid_q;
  assign byte_index_o           = idx_q;
  assign frame_done_o           = done_q;
  assign status_o               = status_q;
  assign frame_length_o         = flen_q;
  assign bytes_received_count_o = total_q;
  assign crc_error_count_o      = crcerr_q;
  assign exception_count_o      = exc_q;
  assign response_count_o       = resp_q;
  assign timeout_count_o        = tmo_q;
  assign io_error_count_o       = ioe_q;

endmodule

`default_nettype wire
